// ===== src/cpt_pkg.sv =====
// Types, widths and codes shared by the closest-point-on-triangle unit.
package cpt_pkg;

  localparam int COORD_W  = 32;
  localparam int DIFF_W   = COORD_W + 1;
  localparam int PROD_W   = 2 * DIFF_W;
  localparam int DOT_W    = PROD_W + 2;
  localparam int HALF_W   = DOT_W / 2;
  localparam int PP_W     = 2 * HALF_W + 2;
  localparam int VPROD_W  = 2 * DOT_W;
  localparam int V_W      = VPROD_W + 1;
  localparam int SUM_W    = V_W + 2;
  localparam int EDGE_W   = DOT_W + 1;
  localparam int BCDEN_W  = DOT_W + 2;
  localparam int PIECE_W  = 35;
  localparam int NPIECE   = 4;
  localparam int TOP_W    = V_W - (NPIECE - 1) * PIECE_W;
  localparam int NPP_W    = PIECE_W + 1 + DIFF_W;
  localparam int NUM_W    = V_W + DIFF_W + 1;
  localparam int QB       = 36;
  localparam int CMP_W    = SUM_W + QB;
  localparam int FIN_W    = QB + 2;
  localparam int FRONT_ST = 9;
  localparam int DIV_ST   = QB + 2;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [DOT_W-1:0]   dot_t;
  typedef logic signed [PP_W-1:0]    pp_t;
  typedef logic signed [VPROD_W-1:0] vprod_t;
  typedef logic signed [V_W-1:0]     v_t;
  typedef logic signed [SUM_W-1:0]   sum_t;
  typedef logic signed [NPP_W-1:0]   npp_t;
  typedef logic signed [NUM_W-1:0]   num_t;

  localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  // operand pairs of the six cross products: d1*d4, d3*d2, d5*d2, d1*d6, d3*d6, d5*d4
  localparam int PA [6] = '{0, 2, 4, 0, 2, 4};
  localparam int PB [6] = '{3, 1, 1, 5, 5, 3};

  typedef enum logic [2:0] {
    REG_A    = 3'd0,
    REG_B    = 3'd1,
    REG_AB   = 3'd2,
    REG_C    = 3'd3,
    REG_AC   = 3'd4,
    REG_BC   = 3'd5,
    REG_FACE = 3'd6
  } region_e;

  typedef struct packed {
    coord_t [2:0] a;
    coord_t [2:0] b;
    coord_t [2:0] c;
    diff_t  [2:0] ab;
    diff_t  [2:0] ac;
    diff_t  [2:0] bc;
  } carry_t;

  typedef struct packed {
    sum_t         den;
    coord_t [2:0] base;
    region_e      region;
    logic         degen;
  } side_t;

  typedef struct packed {
    num_t [2:0] num;
    side_t      side;
  } div_in_t;

  typedef struct packed {
    coord_t [2:0] q;
    region_e      region;
    logic         degen;
  } res_t;

endpackage

// ===== src/cpt_if.sv =====
// Valid/ready channel interfaces for query and result transactions.
interface cpt_in_if;
  import cpt_pkg::*;
  logic   valid;
  logic   ready;
  coord_t ax, ay, az, bx, by_coord, bz, cx, cy, cz, px, py, pz;
  modport source (output valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz, px, py, pz,
                  input ready);
  modport sink (input valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz, px, py, pz,
                output ready);
endinterface

interface cpt_out_if;
  import cpt_pkg::*;
  logic       valid;
  logic       ready;
  coord_t     qx, qy, qz;
  logic [2:0] region;
  logic       degenerate;
  modport source (output valid, qx, qy, qz, region, degenerate, input ready);
  modport sink (input valid, qx, qy, qz, region, degenerate, output ready);
endinterface

// ===== src/cpt_div.sv =====
// Pipelined restoring divider, three lanes, one quotient bit per stage, with final clamp.
module cpt_div (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  cpt_pkg::div_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output cpt_pkg::res_t    out_data_o
);
  import cpt_pkg::*;

  logic [DIV_ST-1:0] v_q, en, vin, ld;
  logic [NUM_W-1:0]  rem_q [QB+1][3];
  logic [QB-1:0]     quo_q [QB+1][3];
  logic [SUM_W-1:0]  dm_q  [QB+1];
  logic [2:0]        neg_q [QB+1];
  side_t             sd_q  [QB+1];
  logic [NUM_W-1:0]  rem0_d [3];
  logic [SUM_W-1:0]  dm0_d;
  logic [2:0]        neg0_d;
  res_t              res_d, res_q;

  assign vin = {v_q[DIV_ST-2:0], in_valid_i};
  always_comb begin
    en[DIV_ST-1] = !v_q[DIV_ST-1] || out_ready_i;
    for (int k = DIV_ST - 2; k >= 0; k--) en[k] = !v_q[k] || en[k+1];
  end
  assign ld         = en & vin;
  assign in_ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= (v_q & ~en) | (vin & en);
    end
  end

  // take magnitudes
  always_comb begin
    num_t n;
    sum_t dn;
    dn    = $signed(in_data_i.side.den);
    dm0_d = (dn < 0) ? -dn : dn;
    for (int i = 0; i < 3; i++) begin
      n         = $signed(in_data_i.num[i]);
      rem0_d[i] = (n < 0) ? -n : n;
      neg0_d[i] = (n < 0) ^ (dn < 0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      for (int i = 0; i < 3; i++) begin
        rem_q[0][i] <= rem0_d[i];
        quo_q[0][i] <= '0;
      end
      dm_q[0]  <= dm0_d;
      neg_q[0] <= neg0_d;
      sd_q[0]  <= in_data_i.side;
    end
  end

  for (genvar s = 1; s <= QB; s++) begin : g_step
    localparam int K = QB - s;
    logic [CMP_W-1:0] dsh;
    logic [2:0]       ge;

    assign dsh = CMP_W'(dm_q[s-1]) << K;
    always_comb begin
      for (int i = 0; i < 3; i++) ge[i] = CMP_W'(rem_q[s-1][i]) >= dsh;
    end

    always_ff @(posedge clk_i) begin
      if (ld[s]) begin
        for (int i = 0; i < 3; i++) begin
          rem_q[s][i] <= ge[i] ? rem_q[s-1][i] - dsh[NUM_W-1:0] : rem_q[s-1][i];
          quo_q[s][i] <= quo_q[s-1][i] | (QB'(ge[i]) << K);
        end
        dm_q[s]  <= dm_q[s-1];
        neg_q[s] <= neg_q[s-1];
        sd_q[s]  <= sd_q[s-1];
      end
    end
  end

  // add offset to base, saturate
  always_comb begin
    logic [QB-2:0]            mag;
    logic signed [QB-1:0]     sq;
    logic signed [FIN_W-1:0]  sm;
    res_d.region = sd_q[QB].region;
    res_d.degen  = sd_q[QB].degen;
    for (int i = 0; i < 3; i++) begin
      mag = quo_q[QB][i][QB-2:0];
      sq  = neg_q[QB][i] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      sm  = FIN_W'($signed(sd_q[QB].base[i])) + FIN_W'(sq);
      priority if (quo_q[QB][i][QB-1]) begin
        res_d.q[i] = neg_q[QB][i] ? COORD_MIN : COORD_MAX;
      end else if (sm > FIN_W'(COORD_MAX)) begin
        res_d.q[i] = COORD_MAX;
      end else if (sm < FIN_W'(COORD_MIN)) begin
        res_d.q[i] = COORD_MIN;
      end else begin
        res_d.q[i] = sm[COORD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[DIV_ST-1]) res_q <= res_d;
  end

  assign out_valid_o = v_q[DIV_ST-1];
  assign out_data_o  = res_q;

endmodule

// ===== src/closest_point_on_triangle_unit.sv =====
// Closest point on a triangle: region test front end feeding a pipelined divider.
// The pipeline has 9 front stages and 38 divider stages.
// Throughput: one transaction per cycle while results are accepted; the 36 one-bit divider stages set the depth.
// Each stage advances when its successor is empty or advancing, so bubbles collapse.
// Reset clears all stage valid bits; data registers are not reset.
module closest_point_on_triangle_unit (
  input logic       clk_i,
  input logic       rst_ni,
  cpt_in_if.sink    in_i,
  cpt_out_if.source out_o
);
  import cpt_pkg::*;

  logic [FRONT_ST-1:0] fv_q, fen, fvin, ld;
  logic    div_ready, div_valid;
  div_in_t div_in;
  res_t    div_res;

  assign fvin = {fv_q[FRONT_ST-2:0], in_i.valid};
  always_comb begin
    fen[FRONT_ST-1] = !fv_q[FRONT_ST-1] || div_ready;
    for (int k = FRONT_ST - 2; k >= 0; k--) fen[k] = !fv_q[k] || fen[k+1];
  end
  assign ld         = fen & fvin;
  assign in_i.ready = fen[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= '0;
    end else begin
      fv_q <= (fv_q & ~fen) | (fvin & fen);
    end
  end

  // edge vectors
  coord_t a_in [3], b_in [3], c_in [3], p_in [3];
  carry_t cr_d0;
  carry_t cr_q [6];
  diff_t  ap_d [3], bp_d [3], cp_d [3];
  diff_t  ap_q [3], bp_q [3], cp_q [3];

  assign a_in[0] = in_i.ax;
  assign a_in[1] = in_i.ay;
  assign a_in[2] = in_i.az;
  assign b_in[0] = in_i.bx;
  assign b_in[1] = in_i.by_coord;
  assign b_in[2] = in_i.bz;
  assign c_in[0] = in_i.cx;
  assign c_in[1] = in_i.cy;
  assign c_in[2] = in_i.cz;
  assign p_in[0] = in_i.px;
  assign p_in[1] = in_i.py;
  assign p_in[2] = in_i.pz;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cr_d0.a[i]  = a_in[i];
      cr_d0.b[i]  = b_in[i];
      cr_d0.c[i]  = c_in[i];
      cr_d0.ab[i] = DIFF_W'(b_in[i]) - DIFF_W'(a_in[i]);
      cr_d0.ac[i] = DIFF_W'(c_in[i]) - DIFF_W'(a_in[i]);
      cr_d0.bc[i] = DIFF_W'(c_in[i]) - DIFF_W'(b_in[i]);
      ap_d[i]     = DIFF_W'(p_in[i]) - DIFF_W'(a_in[i]);
      bp_d[i]     = DIFF_W'(p_in[i]) - DIFF_W'(b_in[i]);
      cp_d[i]     = DIFF_W'(p_in[i]) - DIFF_W'(c_in[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      cr_q[0] <= cr_d0;
      ap_q    <= ap_d;
      bp_q    <= bp_d;
      cp_q    <= cp_d;
    end
  end

  // dot product terms
  prod_t pr_d [6][3], pr_q [6][3];

  always_comb begin
    diff_t ab, ac;
    for (int i = 0; i < 3; i++) begin
      ab        = $signed(cr_q[0].ab[i]);
      ac        = $signed(cr_q[0].ac[i]);
      pr_d[0][i] = PROD_W'(ab) * PROD_W'(ap_q[i]);
      pr_d[1][i] = PROD_W'(ac) * PROD_W'(ap_q[i]);
      pr_d[2][i] = PROD_W'(ab) * PROD_W'(bp_q[i]);
      pr_d[3][i] = PROD_W'(ac) * PROD_W'(bp_q[i]);
      pr_d[4][i] = PROD_W'(ab) * PROD_W'(cp_q[i]);
      pr_d[5][i] = PROD_W'(ac) * PROD_W'(cp_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[1]) begin
      pr_q    <= pr_d;
      cr_q[1] <= cr_q[0];
    end
  end

  // d1..d6
  dot_t dd_d [6];
  dot_t dd_q [4][6];

  always_comb begin
    for (int j = 0; j < 6; j++) begin
      dd_d[j] = DOT_W'(pr_q[j][0]) + DOT_W'(pr_q[j][1]) + DOT_W'(pr_q[j][2]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[2]) begin
      dd_q[0] <= dd_d;
      cr_q[2] <= cr_q[1];
    end
  end

  // cross product partials
  pp_t pp_d [6][4], pp_q [6][4];

  always_comb begin
    dot_t                    x, y;
    logic signed [HALF_W-1:0] xh, yh;
    logic signed [HALF_W:0]   xl, yl;
    for (int j = 0; j < 6; j++) begin
      x  = dd_q[0][PA[j]];
      y  = dd_q[0][PB[j]];
      xh = x[DOT_W-1:HALF_W];
      yh = y[DOT_W-1:HALF_W];
      xl = {1'b0, x[HALF_W-1:0]};
      yl = {1'b0, y[HALF_W-1:0]};
      pp_d[j][0] = PP_W'(xh) * PP_W'(yh);
      pp_d[j][1] = PP_W'(xh) * PP_W'(yl);
      pp_d[j][2] = PP_W'(xl) * PP_W'(yh);
      pp_d[j][3] = PP_W'(xl) * PP_W'(yl);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[3]) begin
      pp_q    <= pp_d;
      dd_q[1] <= dd_q[0];
      cr_q[3] <= cr_q[2];
    end
  end

  vprod_t vp_d [6], vp_q [6];

  always_comb begin
    for (int j = 0; j < 6; j++) begin
      vp_d[j] = (VPROD_W'(pp_q[j][0]) <<< (2 * HALF_W))
              + ((VPROD_W'(pp_q[j][1]) + VPROD_W'(pp_q[j][2])) <<< HALF_W)
              + VPROD_W'(pp_q[j][3]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[4]) begin
      vp_q    <= vp_d;
      dd_q[2] <= dd_q[1];
      cr_q[4] <= cr_q[3];
    end
  end

  v_t va_d, vb_d, vc_d, va_q, vb_q, vc_q;

  assign vc_d = V_W'(vp_q[0]) - V_W'(vp_q[1]);
  assign vb_d = V_W'(vp_q[2]) - V_W'(vp_q[3]);
  assign va_d = V_W'(vp_q[4]) - V_W'(vp_q[5]);

  always_ff @(posedge clk_i) begin
    if (ld[5]) begin
      va_q    <= va_d;
      vb_q    <= vb_d;
      vc_q    <= vc_d;
      dd_q[3] <= dd_q[2];
      cr_q[5] <= cr_q[4];
    end
  end

  // region select
  v_t    s1_d, s2_d, s1_q, s2_q;
  diff_t dir1_d [3], dir2_d [3], dir1_q [3], dir2_q [3];
  side_t sd_d;
  side_t sd_q [3];

  always_comb begin
    dot_t                      d1, d2, d3, d4, d5, d6;
    logic signed [EDGE_W-1:0]  d1m3, d2m6, d3m4, d6m5, d4m3, d5m6;
    logic signed [BCDEN_W-1:0] bcden;
    sum_t                      fden;
    d1    = dd_q[3][0];
    d2    = dd_q[3][1];
    d3    = dd_q[3][2];
    d4    = dd_q[3][3];
    d5    = dd_q[3][4];
    d6    = dd_q[3][5];
    d1m3  = EDGE_W'(d1) - EDGE_W'(d3);
    d2m6  = EDGE_W'(d2) - EDGE_W'(d6);
    d3m4  = EDGE_W'(d3) - EDGE_W'(d4);
    d6m5  = EDGE_W'(d6) - EDGE_W'(d5);
    d4m3  = EDGE_W'(d4) - EDGE_W'(d3);
    d5m6  = EDGE_W'(d5) - EDGE_W'(d6);
    bcden = BCDEN_W'(d4m3) + BCDEN_W'(d5m6);
    fden  = SUM_W'(va_q) + SUM_W'(vb_q) + SUM_W'(vc_q);
    s1_d        = '0;
    s2_d        = '0;
    sd_d.den    = SUM_W'(1);
    sd_d.region = REG_FACE;
    sd_d.degen  = 1'b0;
    for (int i = 0; i < 3; i++) begin
      dir1_d[i]    = $signed(cr_q[5].ab[i]);
      dir2_d[i]    = $signed(cr_q[5].ac[i]);
      sd_d.base[i] = cr_q[5].a[i];
    end
    priority if (d1 <= 0 && d2 <= 0) begin
      sd_d.region = REG_A;
    end else if (d3 >= 0 && d3m4 >= 0) begin
      sd_d.region = REG_B;
      for (int i = 0; i < 3; i++) sd_d.base[i] = cr_q[5].b[i];
    end else if (vc_q <= 0 && d1 >= 0 && d3 <= 0) begin
      sd_d.region = REG_AB;
      if (d1m3 != 0) begin
        s1_d     = V_W'(d1);
        sd_d.den = SUM_W'(d1m3);
      end
    end else if (d6 >= 0 && d6m5 >= 0) begin
      sd_d.region = REG_C;
      for (int i = 0; i < 3; i++) sd_d.base[i] = cr_q[5].c[i];
    end else if (vb_q <= 0 && d2 >= 0 && d6 <= 0) begin
      sd_d.region = REG_AC;
      for (int i = 0; i < 3; i++) dir1_d[i] = $signed(cr_q[5].ac[i]);
      if (d2m6 != 0) begin
        s1_d     = V_W'(d2);
        sd_d.den = SUM_W'(d2m6);
      end
    end else if (va_q <= 0 && d4m3 >= 0 && d5m6 >= 0) begin
      sd_d.region = REG_BC;
      for (int i = 0; i < 3; i++) begin
        sd_d.base[i] = cr_q[5].b[i];
        dir1_d[i]    = $signed(cr_q[5].bc[i]);
      end
      if (bcden != 0) begin
        s1_d     = V_W'(d4m3);
        sd_d.den = SUM_W'(bcden);
      end
    end else if (fden == 0) begin
      sd_d.degen = 1'b1;
    end else begin
      s1_d     = vb_q;
      s2_d     = vc_q;
      sd_d.den = fden;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[6]) begin
      s1_q    <= s1_d;
      s2_q    <= s2_d;
      dir1_q  <= dir1_d;
      dir2_q  <= dir2_d;
      sd_q[0] <= sd_d;
    end
  end

  // numerator partials
  npp_t npp_d [3][2][NPIECE], npp_q [3][2][NPIECE];

  always_comb begin
    v_t    sc;
    diff_t dr;
    for (int c = 0; c < 3; c++) begin
      for (int s = 0; s < 2; s++) begin
        sc = (s == 0) ? s1_q : s2_q;
        dr = (s == 0) ? dir1_q[c] : dir2_q[c];
        for (int m = 0; m < NPIECE - 1; m++) begin
          npp_d[c][s][m] = NPP_W'($signed({1'b0, sc[m*PIECE_W +: PIECE_W]})) * NPP_W'(dr);
        end
        npp_d[c][s][NPIECE-1] = NPP_W'($signed(sc[V_W-1 -: TOP_W])) * NPP_W'(dr);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[7]) begin
      npp_q   <= npp_d;
      sd_q[1] <= sd_q[0];
    end
  end

  num_t num_d [3], num_q [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      num_d[c] = '0;
      for (int s = 0; s < 2; s++) begin
        for (int m = 0; m < NPIECE; m++) begin
          num_d[c] = num_d[c] + (NUM_W'(npp_q[c][s][m]) <<< (m * PIECE_W));
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[8]) begin
      num_q   <= num_d;
      sd_q[2] <= sd_q[1];
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) div_in.num[c] = num_q[c];
    div_in.side = sd_q[2];
  end

  cpt_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fv_q[FRONT_ST-1]),
    .in_ready_o  (div_ready),
    .in_data_i   (div_in),
    .out_valid_o (div_valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (div_res)
  );

  assign out_o.valid      = div_valid;
  assign out_o.qx         = div_res.q[0];
  assign out_o.qy         = div_res.q[1];
  assign out_o.qz         = div_res.q[2];
  assign out_o.region     = div_res.region;
  assign out_o.degenerate = div_res.degen;

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the closest-point-on-triangle unit.
module tb_top;
  import cpt_pkg::*;

  typedef logic signed [255:0] big_t;
  typedef coord_t [11:0] query_t;

  typedef struct {
    query_t pts;
    bit     typed;
    res_t   res;
  } row_t;

  localparam coord_t ONE = 32'sh0001_0000;
  localparam int TIMEOUT_CYCLES = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  cpt_in_if  in_if ();
  cpt_out_if out_if ();

  closest_point_on_triangle_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #1 clk_i = ~clk_i;

  res_t   pending_q[$];
  row_t   rows[$];
  int     send_idle_pct;
  int     recv_idle_pct;
  int     mismatches;
  int     checked;
  int     sent;
  int     cycles;
  int     region_hits[7];
  int     degen_hits;

  function automatic big_t dot3(big_t u0, big_t u1, big_t u2, big_t v0, big_t v1, big_t v2);
    return u0 * v0 + u1 * v1 + u2 * v2;
  endfunction

  function automatic big_t ratio(big_t n, big_t d);
    big_t q;
    big_t lim;
    lim = big_t'(1) <<< 62;
    q = n / d;
    if (q > lim) q = lim;
    if (q < -lim) q = -lim;
    return q;
  endfunction

  function automatic coord_t sat(big_t v);
    big_t hi;
    big_t lo;
    hi = big_t'(COORD_MAX);
    lo = big_t'(COORD_MIN);
    if (v > hi) return COORD_MAX;
    if (v < lo) return COORD_MIN;
    return coord_t'(v);
  endfunction

  function automatic res_t closest_point(query_t p);
    big_t a[3], b[3], c[3], pt[3], ab[3], ac[3], ap[3], bp[3], cp[3], bc[3], q[3];
    big_t d1, d2, d3, d4, d5, d6, va, vb, vc, num, den;
    res_t r;
    for (int i = 0; i < 3; i++) begin
      a[i] = p[i];
      b[i] = p[3 + i];
      c[i] = p[6 + i];
      pt[i] = p[9 + i];
    end
    for (int i = 0; i < 3; i++) begin
      ab[i] = b[i] - a[i];
      ac[i] = c[i] - a[i];
      ap[i] = pt[i] - a[i];
      bp[i] = pt[i] - b[i];
      cp[i] = pt[i] - c[i];
      bc[i] = c[i] - b[i];
    end
    d1 = dot3(ab[0], ab[1], ab[2], ap[0], ap[1], ap[2]);
    d2 = dot3(ac[0], ac[1], ac[2], ap[0], ap[1], ap[2]);
    d3 = dot3(ab[0], ab[1], ab[2], bp[0], bp[1], bp[2]);
    d4 = dot3(ac[0], ac[1], ac[2], bp[0], bp[1], bp[2]);
    d5 = dot3(ab[0], ab[1], ab[2], cp[0], cp[1], cp[2]);
    d6 = dot3(ac[0], ac[1], ac[2], cp[0], cp[1], cp[2]);
    vc = d1 * d4 - d3 * d2;
    vb = d5 * d2 - d1 * d6;
    va = d3 * d6 - d5 * d4;
    r.degen = 1'b0;
    if (d1 <= 0 && d2 <= 0) begin
      r.region = REG_A;
      q = a;
    end else if (d3 >= 0 && d3 - d4 >= 0) begin
      r.region = REG_B;
      q = b;
    end else if (vc <= 0 && d1 >= 0 && d3 <= 0) begin
      r.region = REG_AB;
      den = d1 - d3;
      for (int i = 0; i < 3; i++) q[i] = a[i] + (den != 0 ? ratio(d1 * ab[i], den) : 0);
    end else if (d6 >= 0 && d6 - d5 >= 0) begin
      r.region = REG_C;
      q = c;
    end else if (vb <= 0 && d2 >= 0 && d6 <= 0) begin
      r.region = REG_AC;
      den = d2 - d6;
      for (int i = 0; i < 3; i++) q[i] = a[i] + (den != 0 ? ratio(d2 * ac[i], den) : 0);
    end else if (va <= 0 && d4 - d3 >= 0 && d5 - d6 >= 0) begin
      r.region = REG_BC;
      num = d4 - d3;
      den = num + (d5 - d6);
      for (int i = 0; i < 3; i++) q[i] = b[i] + (den != 0 ? ratio(num * bc[i], den) : 0);
    end else begin
      r.region = REG_FACE;
      den = va + vb + vc;
      if (den == 0) begin
        r.degen = 1'b1;
        q = a;
      end else begin
        for (int i = 0; i < 3; i++) q[i] = a[i] + ratio(vb * ab[i] + vc * ac[i], den);
      end
    end
    for (int i = 0; i < 3; i++) r.q[i] = sat(q[i]);
    return r;
  endfunction

  function automatic query_t mk(coord_t a0, coord_t a1, coord_t a2, coord_t b0, coord_t b1,
                               coord_t b2, coord_t c0, coord_t c1, coord_t c2, coord_t p0,
                               coord_t p1, coord_t p2);
    query_t p;
    p = '{p2, p1, p0, c2, c1, c0, b2, b1, b0, a2, a1, a0};
    return p;
  endfunction

  task automatic add_row(query_t p, bit typed, coord_t x, coord_t y, coord_t z, region_e rg);
    row_t r;
    r.pts = p;
    r.typed = typed;
    r.res.q = '{z, y, x};
    r.res.region = rg;
    r.res.degen = 1'b0;
    rows.push_back(r);
  endtask

  function automatic coord_t grid_val();
    coord_t v;
    v = coord_t'($signed($urandom_range(16)) - 8) <<< 14;
    if ($urandom_range(1)) v = v + coord_t'($urandom_range(16383));
    return v;
  endfunction

  function automatic query_t rand_query();
    query_t p;
    int kind;
    int k;
    kind = $urandom_range(99);
    for (int i = 0; i < 12; i++) p[i] = kind < 25 ? coord_t'($urandom) : grid_val();
    if (kind >= 60 && kind < 80) begin
      k = $urandom_range(6) - 3;
      for (int i = 0; i < 3; i++) p[6 + i] = p[i] + coord_t'(k) * ((p[3 + i] - p[i]) >>> 1);
    end else if (kind >= 80 && kind < 86) begin
      for (int i = 0; i < 3; i++) p[3 + 3 * $urandom_range(1) + i] = p[i];
    end
    return p;
  endfunction

  task automatic send(query_t p, bit typed, res_t res);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    {in_if.pz, in_if.py, in_if.px, in_if.cz, in_if.cy, in_if.cx,
     in_if.bz, in_if.by_coord, in_if.bx, in_if.az, in_if.ay, in_if.ax} <= p;
    in_if.valid <= 1'b1;
    do @(posedge clk_i); while (!in_if.ready);
    pending_q.push_back(typed ? res : closest_point(p));
    sent++;
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    out_if.ready <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      checked++;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction q=(%0d,%0d,%0d)",
                                       out_if.qx, out_if.qy, out_if.qz);
      end else begin
        want = pending_q.pop_front();
        region_hits[want.region]++;
        if (want.degen) degen_hits++;
        if (out_if.qx !== want.q[0] || out_if.qy !== want.q[1] || out_if.qz !== want.q[2] ||
            out_if.region !== want.region || out_if.degenerate !== want.degen) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch #%0d: expected q=(%0d,%0d,%0d) region %0d degen %0b, got q=(%0d,%0d,%0d) region %0d degen %0b",
                     checked, want.q[0], want.q[1], want.q[2], want.region, want.degen,
                     out_if.qx, out_if.qy, out_if.qz, out_if.region, out_if.degenerate);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > TIMEOUT_CYCLES) begin
      $display("timeout with %0d results outstanding", pending_q.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    res_t none;
    none = '0;
    in_if.valid = 1'b0;
    {in_if.pz, in_if.py, in_if.px, in_if.cz, in_if.cy, in_if.cx,
     in_if.bz, in_if.by_coord, in_if.bx, in_if.az, in_if.ay, in_if.ax} = '0;
    out_if.ready = 1'b0;
    mismatches = 0;
    checked = 0;
    sent = 0;
    cycles = 0;
    degen_hits = 0;
    region_hits = '{default: 0};
    send_idle_pct = 18;
    recv_idle_pct = 51;

    add_row('0, 1, 0, 0, 0, REG_A);
    add_row({12{COORD_MAX}}, 1, COORD_MAX, COORD_MAX, COORD_MAX, REG_A);
    add_row({12{COORD_MIN}}, 1, COORD_MIN, COORD_MIN, COORD_MIN, REG_A);
    add_row(mk(0, 0, 0, ONE, 0, 0, 0, ONE, 0, -ONE, -ONE, 0), 1, 0, 0, 0, REG_A);
    add_row(mk(0, 0, 0, ONE, 0, 0, 0, ONE, 0, 2 * ONE, -ONE, 0), 1, ONE, 0, 0, REG_B);
    add_row(mk(0, 0, 0, ONE, 0, 0, 0, ONE, 0, -ONE, 2 * ONE, 0), 1, 0, ONE, 0, REG_C);
    add_row(mk(0, 0, 0, ONE, 0, 0, 0, ONE, 0, ONE / 2, -ONE, 0), 0, 0, 0, 0, REG_AB);
    add_row(mk(0, 0, 0, ONE, 0, 0, 0, ONE, 0, -ONE, ONE / 2, 0), 0, 0, 0, 0, REG_AC);
    add_row(mk(0, 0, 0, ONE, 0, 0, 0, ONE, 0, ONE, ONE, 0), 0, 0, 0, 0, REG_BC);
    add_row(mk(0, 0, 0, ONE, 0, 0, 0, ONE, 0, ONE / 4, ONE / 4, 5 * ONE), 0, 0, 0, 0,
            REG_FACE);
    add_row(mk(0, 0, 0, 2 * ONE, 0, 0, ONE, 0, 0, ONE, ONE, 0), 0, 0, 0, 0, REG_FACE);
    add_row(mk(0, 0, 0, 0, 0, 0, ONE, 0, 0, ONE / 2, ONE, 0), 0, 0, 0, 0, REG_AB);
    add_row(mk(0, 0, 0, ONE, 0, 0, 0, 0, 0, ONE / 2, -ONE, ONE), 0, 0, 0, 0, REG_AC);
    add_row(mk(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX,
               COORD_MIN, COORD_MAX, 0, COORD_MAX, COORD_MIN, COORD_MAX), 0, 0, 0, 0, REG_A);
    add_row(mk(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN,
               0, 0, 0, 0, COORD_MIN, 0), 0, 0, 0, 0, REG_A);
    add_row(mk(COORD_MIN, 0, COORD_MAX, COORD_MAX, COORD_MIN, 0, 0, COORD_MAX, COORD_MIN,
               -1, 1, -1), 0, 0, 0, 0, REG_A);

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (rows[i]) send(rows[i].pts, rows[i].typed, rows[i].res);
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = ph == 0 ? 18 : (ph == 1 ? 51 : 0);
      recv_idle_pct = ph == 0 ? 51 : (ph == 1 ? 18 : 0);
      repeat (345) send(rand_query(), 0, none);
    end
    in_if.valid <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);

    $display("sent %0d queries, checked %0d results, %0d mismatches", sent, checked, mismatches);
    $display("regions A/B/AB/C/AC/BC/face: %0d/%0d/%0d/%0d/%0d/%0d/%0d, degenerate faces %0d",
             region_hits[0], region_hits[1], region_hits[2], region_hits[3], region_hits[4],
             region_hits[5], region_hits[6], degen_hits);
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== closest_point_on_triangle_unit.f =====
src/cpt_pkg.sv
src/cpt_if.sv
src/cpt_div.sv
src/closest_point_on_triangle_unit.sv
sim/tb_top.sv
